### rtl/btxp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btxp_pkg
// Shared codes and types for the legacy transaction stream parser.
// ----------------------------------------------------------------------------
package btxp_pkg;

    // Field kinds, also used as parser phase codes
    localparam logic [3:0] PH_VERSION   = 4'd0;
    localparam logic [3:0] PH_INCOUNT   = 4'd1;
    localparam logic [3:0] PH_TXID      = 4'd2;
    localparam logic [3:0] PH_PREVIDX   = 4'd3;
    localparam logic [3:0] PH_INSLEN    = 4'd4;
    localparam logic [3:0] PH_INSCRIPT  = 4'd5;
    localparam logic [3:0] PH_SEQ       = 4'd6;
    localparam logic [3:0] PH_OUTCOUNT  = 4'd7;
    localparam logic [3:0] PH_AMOUNT    = 4'd8;
    localparam logic [3:0] PH_OUTSLEN   = 4'd9;
    localparam logic [3:0] PH_OUTSCRIPT = 4'd10;
    localparam logic [3:0] PH_LOCK      = 4'd11;
    localparam logic [3:0] PH_DISCARD   = 4'd12;

    // Events
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_INPUT    = 2'd1;
    localparam logic [1:0] EV_OUTPUT   = 2'd2;
    localparam logic [1:0] EV_TX       = 2'd3;

    // Status
    localparam logic [1:0] ST_BUSY     = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // Field sizes
    localparam logic [5:0] TXID_BYTES  = 6'd32;
    localparam logic [5:0] WORD_BYTES  = 6'd4;
    localparam logic [5:0] AMT_BYTES   = 6'd8;

    // CompactSize prefixes
    localparam logic [7:0] CS_PFX_16   = 8'hfd;
    localparam logic [7:0] CS_PFX_32   = 8'hfe;

    typedef struct packed {
        logic [3:0]  phase;
        logic [5:0]  fbc;       // bytes of current field seen
        logic [3:0]  vlen;      // CompactSize extra byte count
        logic [63:0] acc;       // little-endian accumulator
        logic [63:0] rem;       // inputs/outputs left
        logic [63:0] idx;       // current input/output index
        logic [63:0] sleft;     // script bytes left
    } t_state;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [7:0]  byte_out;
        logic [63:0] decoded_value;
        logic        field_end;
        logic [1:0]  event_kind;
        logic [63:0] element_number;
        logic [1:0]  status;
    } t_result;

endpackage

### rtl/btxp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btxp_step
// Next-state and result logic for one transaction byte.
// ----------------------------------------------------------------------------
module btxp_step (
    input  btxp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output btxp_pkg::t_state  o_state,
    output btxp_pkg::t_result o_result
);

    logic [5:0]  w_fbc_inc;
    logic [5:0]  w_fbc_dec;
    logic [63:0] w_rem_dec;
    logic        w_rem_more;
    logic [63:0] w_sleft_dec;
    logic        w_sleft_last;
    logic [63:0] w_idx_inc;

    assign w_fbc_inc    = i_state.fbc + 6'd1;
    assign w_fbc_dec    = i_state.fbc - 6'd1;
    assign w_rem_dec    = i_state.rem - 64'd1;
    assign w_rem_more   = (i_state.rem != 64'd1);
    assign w_sleft_dec  = i_state.sleft - 64'd1;
    assign w_sleft_last = (i_state.sleft == 64'd1);
    assign w_idx_inc    = i_state.idx + 64'd1;

    always_comb begin
        btxp_pkg::t_state n;
        logic [3:0]  cur;
        logic [63:0] dec;
        logic        fend;
        logic [1:0]  ev;
        logic [1:0]  st;
        logic        cs_done;
        logic [63:0] cs_val;
        logic [2:0]  lane;
        logic [5:0]  flen;

        n       = i_state;
        cur     = i_state.phase;
        dec     = '0;
        fend    = 1'b0;
        ev      = btxp_pkg::EV_NONE;
        st      = btxp_pkg::ST_BUSY;
        cs_done = 1'b0;
        cs_val  = '0;
        lane    = i_state.fbc[2:0];
        flen    = btxp_pkg::WORD_BYTES;

        unique case (i_state.phase)
            btxp_pkg::PH_VERSION, btxp_pkg::PH_PREVIDX, btxp_pkg::PH_SEQ,
            btxp_pkg::PH_AMOUNT, btxp_pkg::PH_LOCK: begin
                n.acc[{lane, 3'b000} +: 8] = i_state.acc[{lane, 3'b000} +: 8] | i_byte;
                n.fbc = w_fbc_inc;
                dec   = n.acc;
                if (i_state.phase == btxp_pkg::PH_AMOUNT) begin
                    flen = btxp_pkg::AMT_BYTES;
                end
                if (w_fbc_inc >= flen) begin
                    fend  = 1'b1;
                    n.fbc = '0;
                    n.acc = '0;
                    case (i_state.phase)
                        btxp_pkg::PH_VERSION: n.phase = btxp_pkg::PH_INCOUNT;
                        btxp_pkg::PH_PREVIDX: n.phase = btxp_pkg::PH_INSLEN;
                        btxp_pkg::PH_AMOUNT:  n.phase = btxp_pkg::PH_OUTSLEN;
                        btxp_pkg::PH_SEQ: begin
                            ev      = btxp_pkg::EV_INPUT;
                            n.idx   = w_idx_inc;
                            n.rem   = w_rem_dec;
                            n.phase = w_rem_more ? btxp_pkg::PH_TXID
                                                 : btxp_pkg::PH_OUTCOUNT;
                        end
                        default: ;
                    endcase
                end
            end
            btxp_pkg::PH_TXID: begin
                n.fbc = w_fbc_inc;
                if (w_fbc_inc >= btxp_pkg::TXID_BYTES) begin
                    fend    = 1'b1;
                    n.fbc   = '0;
                    n.phase = btxp_pkg::PH_PREVIDX;
                end
            end
            btxp_pkg::PH_INCOUNT, btxp_pkg::PH_INSLEN, btxp_pkg::PH_OUTCOUNT,
            btxp_pkg::PH_OUTSLEN: begin
                if (i_state.fbc == 6'd0) begin
                    // prefix byte
                    if (i_byte < btxp_pkg::CS_PFX_16) begin
                        cs_done = 1'b1;
                        cs_val  = {56'd0, i_byte};
                    end else begin
                        if (i_byte == btxp_pkg::CS_PFX_16) begin
                            n.vlen = 4'd2;
                        end else if (i_byte == btxp_pkg::CS_PFX_32) begin
                            n.vlen = 4'd4;
                        end else begin
                            n.vlen = 4'd8;
                        end
                        n.acc = '0;
                        n.fbc = 6'd1;
                    end
                end else begin
                    lane = w_fbc_dec[2:0];
                    n.acc[{lane, 3'b000} +: 8] = i_state.acc[{lane, 3'b000} +: 8] | i_byte;
                    n.fbc = w_fbc_inc;
                    dec   = n.acc;
                    if (w_fbc_inc >= ({2'b00, i_state.vlen} + 6'd1)) begin
                        cs_done = 1'b1;
                        cs_val  = n.acc;
                    end
                end
                if (cs_done) begin
                    fend   = 1'b1;
                    dec    = cs_val;
                    n.fbc  = '0;
                    n.vlen = '0;
                    n.acc  = '0;
                    case (i_state.phase)
                        btxp_pkg::PH_INCOUNT: begin
                            n.rem   = cs_val;
                            n.idx   = '0;
                            n.phase = (cs_val != 64'd0) ? btxp_pkg::PH_TXID
                                                        : btxp_pkg::PH_OUTCOUNT;
                        end
                        btxp_pkg::PH_OUTCOUNT: begin
                            n.rem   = cs_val;
                            n.idx   = '0;
                            n.phase = (cs_val != 64'd0) ? btxp_pkg::PH_AMOUNT
                                                        : btxp_pkg::PH_LOCK;
                        end
                        btxp_pkg::PH_INSLEN: begin
                            n.sleft = cs_val;
                            n.phase = (cs_val != 64'd0) ? btxp_pkg::PH_INSCRIPT
                                                        : btxp_pkg::PH_SEQ;
                        end
                        default: begin
                            n.sleft = cs_val;
                            if (cs_val != 64'd0) begin
                                n.phase = btxp_pkg::PH_OUTSCRIPT;
                            end else begin
                                ev      = btxp_pkg::EV_OUTPUT;
                                n.idx   = w_idx_inc;
                                n.rem   = w_rem_dec;
                                n.phase = w_rem_more ? btxp_pkg::PH_AMOUNT
                                                     : btxp_pkg::PH_LOCK;
                            end
                        end
                    endcase
                end
            end
            btxp_pkg::PH_INSCRIPT: begin
                n.sleft = w_sleft_dec;
                if (w_sleft_last) begin
                    fend    = 1'b1;
                    n.phase = btxp_pkg::PH_SEQ;
                end
            end
            btxp_pkg::PH_OUTSCRIPT: begin
                n.sleft = w_sleft_dec;
                if (w_sleft_last) begin
                    fend    = 1'b1;
                    ev      = btxp_pkg::EV_OUTPUT;
                    n.idx   = w_idx_inc;
                    n.rem   = w_rem_dec;
                    n.phase = w_rem_more ? btxp_pkg::PH_AMOUNT : btxp_pkg::PH_LOCK;
                end
            end
            default: begin
                cur = btxp_pkg::PH_DISCARD;
                st  = btxp_pkg::ST_ERROR;
            end
        endcase

        // end-of-buffer handling
        if (cur == btxp_pkg::PH_DISCARD) begin
            if (i_last) begin
                n       = '0;
                n.phase = btxp_pkg::PH_VERSION;
            end
        end else if (cur == btxp_pkg::PH_LOCK && fend) begin
            n = '0;
            if (i_last) begin
                ev      = btxp_pkg::EV_TX;
                st      = btxp_pkg::ST_OK;
                n.phase = btxp_pkg::PH_VERSION;
            end else begin
                st      = btxp_pkg::ST_ERROR;
                n.phase = btxp_pkg::PH_DISCARD;
            end
        end else if (i_last) begin
            st      = btxp_pkg::ST_ERROR;
            n       = '0;
            n.phase = btxp_pkg::PH_VERSION;
        end

        o_state                 = n;
        o_result.field_kind     = cur;
        o_result.byte_out       = i_byte;
        o_result.decoded_value  = dec;
        o_result.field_end      = fend;
        o_result.event_kind     = ev;
        o_result.element_number = i_state.idx;
        o_result.status         = st;
    end

endmodule

### rtl/bitcoin_tx_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcoin_tx_stream_parser
// Byte-stream parser for serialized legacy transactions.
// ----------------------------------------------------------------------------
// Takes one transaction byte per transaction on the input channel and returns
// one tagged result per byte: field kind, the byte itself, the decoded
// little-endian or CompactSize value, field end, input/output/tx completion
// events, the current element index and a status. Throughput is one byte per
// clock while the result channel is not stalled; each byte passes through the
// input register, then through the parser update logic into the result
// register. Updating the parser state for a single byte at a time is what
// sets that rate. A result waiting on the output does not block the input
// register from filling. Bytes after a lock time without the last-byte mark
// are reported as discarded with status error until the next marked byte.
// ----------------------------------------------------------------------------
module bitcoin_tx_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_field_kind,
    output logic [7:0]  o_byte_out,
    output logic [63:0] o_decoded_value,
    output logic        o_field_end,
    output logic [1:0]  o_event_kind,
    output logic [63:0] o_element_number,
    output logic [1:0]  o_status
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    btxp_pkg::t_state  r_state;
    btxp_pkg::t_state  n_state;

    // result register
    logic              r_out_valid;
    btxp_pkg::t_result r_result;
    btxp_pkg::t_result n_result;

    logic w_advance;

    // Byte moves from input register to result register when the result slot
    // is free or being drained this cycle.
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    btxp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Parser state only moves when a byte is committed to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: btxp_pkg::PH_VERSION, default: '0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_field_kind     = r_result.field_kind;
    assign o_byte_out       = r_result.byte_out;
    assign o_decoded_value  = r_result.decoded_value;
    assign o_field_end      = r_result.field_end;
    assign o_event_kind     = r_result.event_kind;
    assign o_element_number = r_result.element_number;
    assign o_status         = r_result.status;

endmodule

### rtl/btxp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btxp_checker
// Port-level checks for the transaction stream parser, bound to the top.
// ----------------------------------------------------------------------------
module btxp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_field_kind,
    input logic [7:0]  o_byte_out,
    input logic        o_field_end,
    input logic [1:0]  o_event_kind,
    input logic [1:0]  o_status
);

    // success only on the closing lock-time byte
    a_ok_on_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == btxp_pkg::ST_OK) |->
        (o_field_kind == btxp_pkg::PH_LOCK && o_field_end
         && o_event_kind == btxp_pkg::EV_TX))
        else $error("ok status outside final lock-time byte");

    a_tx_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == btxp_pkg::EV_TX) |-> (o_status == btxp_pkg::ST_OK))
        else $error("tx complete without ok status");

    a_discard_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_field_kind == btxp_pkg::PH_DISCARD) |->
        (o_status == btxp_pkg::ST_ERROR && o_event_kind == btxp_pkg::EV_NONE))
        else $error("discarded byte without error status");

    a_input_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == btxp_pkg::EV_INPUT) |->
        (o_field_kind == btxp_pkg::PH_SEQ && o_field_end))
        else $error("input complete outside sequence end");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_byte_out)))
        else $error("stalled result dropped or changed");

endmodule

bind bitcoin_tx_stream_parser btxp_checker u_btxp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_field_kind (o_field_kind),
    .o_byte_out   (o_byte_out),
    .o_field_end  (o_field_end),
    .o_event_kind (o_event_kind),
    .o_status     (o_status)
);

### tb/tb_bitcoin_tx_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitcoin_tx_stream_parser
// Self-checking bench for the legacy tx byte-stream parser.
// ----------------------------------------------------------------------------
// Bytes of serialized txs are pushed one per input transaction. A behavioral
// parser inside the bench tags each accepted byte and queues the expected
// result; every result transaction is compared field by field against the
// head of that queue. Stimulus is a few hand-built streams (empty tx, early
// end, run past lock time), a back-pressure burst, then random streams:
// mostly well-formed txs with random content and mixed CompactSize forms,
// plus truncated txs, txs running past lock time, huge counts and noise.
// ----------------------------------------------------------------------------
module tb_bitcoin_tx_stream_parser;

    localparam logic [7:0] CS_PFX_64   = 8'hff;  // 9-byte CompactSize prefix
    localparam int         STALL_LIMIT = 3000;   // cycles with no transaction at all
    localparam int         LONG_HOLD   = 80;     // receiver hold-off, in cycles

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_field_kind;
    logic [7:0]  o_byte_out;
    logic [63:0] o_decoded_value;
    logic        o_field_end;
    logic [1:0]  o_event_kind;
    logic [63:0] o_element_number;
    logic [1:0]  o_status;

    bitcoin_tx_stream_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_field_kind     (o_field_kind),
        .o_byte_out       (o_byte_out),
        .o_decoded_value  (o_decoded_value),
        .o_field_end      (o_field_end),
        .o_event_kind     (o_event_kind),
        .o_element_number (o_element_number),
        .o_status         (o_status)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    btxp_pkg::t_result tagged_bytes[$];   // expected results, oldest first
    logic [7:0]  tx_bytes[$];       // stream under construction

    int unsigned send_idle_pct;     // chance per cycle that the sender holds back
    int unsigned recv_idle_pct;     // chance per cycle that the receiver stalls
    bit          tx_fast;           // current stream goes out back to back
    int unsigned rx_hold_req;       // long hold-off request for the receiver
    int unsigned rx_hold_left;
    int unsigned rx_burst_left;
    int unsigned stall_cycles;

    int unsigned err_cnt;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned tx_ok_cnt;
    int unsigned tx_bad_cnt;

    // ------------------------------------------------------------------------
    // Behavioral parser: mirrors the block's state, one call per accepted byte
    // ------------------------------------------------------------------------
    logic [3:0]  p_phase;
    logic [5:0]  p_cnt;     // bytes of the current field seen so far
    logic [3:0]  p_vlen;    // extra CompactSize bytes after the prefix
    logic [63:0] p_acc;     // little-endian gather
    logic [63:0] p_left;    // inputs or outputs still to come
    logic [63:0] p_idx;     // current input or output index
    logic [63:0] p_sbytes;  // script bytes still to come

    function automatic void clear_parser();
        p_phase  = btxp_pkg::PH_VERSION;
        p_cnt    = '0;
        p_vlen   = '0;
        p_acc    = '0;
        p_left   = '0;
        p_idx    = '0;
        p_sbytes = '0;
    endfunction

    // step to the next input/output; pick where to go once the list is done
    function automatic logic [3:0] next_element(input logic [3:0] more,
                                                input logic [3:0] done);
        p_idx  = p_idx + 64'd1;
        p_left = p_left - 64'd1;
        return (p_left != 0) ? more : done;
    endfunction

    function automatic btxp_pkg::t_result parse_byte(input logic [7:0] b,
                                                     input logic last);
        btxp_pkg::t_result r;
        logic [3:0]  cur;
        logic [3:0]  nxt;
        logic        cs_done;
        logic [63:0] cs_val;
        cur     = p_phase;
        nxt     = p_phase;
        cs_done = 1'b0;
        cs_val  = '0;
        r       = '0;
        r.byte_out       = b;
        r.element_number = p_idx;   // index before this byte's update
        case (cur)
            btxp_pkg::PH_VERSION, btxp_pkg::PH_PREVIDX, btxp_pkg::PH_SEQ,
            btxp_pkg::PH_AMOUNT, btxp_pkg::PH_LOCK: begin
                p_acc = p_acc | (64'(b) << (8 * p_cnt[2:0]));
                p_cnt = p_cnt + 6'd1;
                r.decoded_value = p_acc;
                if (p_cnt >= ((cur == btxp_pkg::PH_AMOUNT) ? btxp_pkg::AMT_BYTES
                                                           : btxp_pkg::WORD_BYTES)) begin
                    r.field_end = 1'b1;
                    p_cnt = '0;
                    p_acc = '0;
                    case (cur)
                        btxp_pkg::PH_VERSION: nxt = btxp_pkg::PH_INCOUNT;
                        btxp_pkg::PH_PREVIDX: nxt = btxp_pkg::PH_INSLEN;
                        btxp_pkg::PH_AMOUNT:  nxt = btxp_pkg::PH_OUTSLEN;
                        btxp_pkg::PH_SEQ: begin
                            r.event_kind = btxp_pkg::EV_INPUT;
                            nxt = next_element(btxp_pkg::PH_TXID, btxp_pkg::PH_OUTCOUNT);
                        end
                        default: ;
                    endcase
                end
            end
            btxp_pkg::PH_TXID: begin
                p_cnt = p_cnt + 6'd1;
                if (p_cnt >= btxp_pkg::TXID_BYTES) begin
                    r.field_end = 1'b1;
                    p_cnt = '0;
                    nxt = btxp_pkg::PH_PREVIDX;
                end
            end
            btxp_pkg::PH_INCOUNT, btxp_pkg::PH_INSLEN, btxp_pkg::PH_OUTCOUNT,
            btxp_pkg::PH_OUTSLEN: begin
                if (p_cnt == '0) begin
                    if (b < btxp_pkg::CS_PFX_16) begin
                        cs_done = 1'b1;
                        cs_val  = 64'(b);
                    end else begin
                        p_vlen = (b == btxp_pkg::CS_PFX_16) ? 4'd2 :
                                 (b == btxp_pkg::CS_PFX_32) ? 4'd4 : 4'd8;
                        p_acc  = '0;
                        p_cnt  = 6'd1;
                    end
                end else begin
                    p_acc = p_acc | (64'(b) << (8 * 3'(p_cnt - 6'd1)));
                    p_cnt = p_cnt + 6'd1;
                    r.decoded_value = p_acc;
                    if (p_cnt >= 6'(p_vlen) + 6'd1) begin
                        cs_done = 1'b1;
                        cs_val  = p_acc;
                    end
                end
                if (cs_done) begin
                    r.field_end     = 1'b1;
                    r.decoded_value = cs_val;
                    p_cnt  = '0;
                    p_vlen = '0;
                    p_acc  = '0;
                    case (cur)
                        btxp_pkg::PH_INCOUNT: begin
                            p_left = cs_val;
                            p_idx  = '0;
                            nxt = (cs_val != 0) ? btxp_pkg::PH_TXID : btxp_pkg::PH_OUTCOUNT;
                        end
                        btxp_pkg::PH_OUTCOUNT: begin
                            p_left = cs_val;
                            p_idx  = '0;
                            nxt = (cs_val != 0) ? btxp_pkg::PH_AMOUNT : btxp_pkg::PH_LOCK;
                        end
                        btxp_pkg::PH_INSLEN: begin
                            p_sbytes = cs_val;
                            nxt = (cs_val != 0) ? btxp_pkg::PH_INSCRIPT : btxp_pkg::PH_SEQ;
                        end
                        default: begin
                            p_sbytes = cs_val;
                            if (cs_val != 0) begin
                                nxt = btxp_pkg::PH_OUTSCRIPT;
                            end else begin
                                // empty output script closes the output here
                                r.event_kind = btxp_pkg::EV_OUTPUT;
                                nxt = next_element(btxp_pkg::PH_AMOUNT, btxp_pkg::PH_LOCK);
                            end
                        end
                    endcase
                end
            end
            btxp_pkg::PH_INSCRIPT: begin
                p_sbytes = p_sbytes - 64'd1;
                if (p_sbytes == 0) begin
                    r.field_end = 1'b1;
                    nxt = btxp_pkg::PH_SEQ;
                end
            end
            btxp_pkg::PH_OUTSCRIPT: begin
                p_sbytes = p_sbytes - 64'd1;
                if (p_sbytes == 0) begin
                    r.field_end  = 1'b1;
                    r.event_kind = btxp_pkg::EV_OUTPUT;
                    nxt = next_element(btxp_pkg::PH_AMOUNT, btxp_pkg::PH_LOCK);
                end
            end
            default: begin
                cur = btxp_pkg::PH_DISCARD;
                r.status = btxp_pkg::ST_ERROR;
            end
        endcase

        p_phase = nxt;
        if (cur == btxp_pkg::PH_DISCARD) begin
            if (last) clear_parser();
        end else if (cur == btxp_pkg::PH_LOCK && r.field_end) begin
            if (last) begin
                r.event_kind = btxp_pkg::EV_TX;
                r.status     = btxp_pkg::ST_OK;
                clear_parser();
            end else begin
                // lock time done but the buffer goes on: swallow until marked byte
                r.status = btxp_pkg::ST_ERROR;
                clear_parser();
                p_phase = btxp_pkg::PH_DISCARD;
            end
        end else if (last) begin
            // early end; an element completed on this byte keeps its event
            r.status = btxp_pkg::ST_ERROR;
            clear_parser();
        end
        r.field_kind = cur;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    function automatic void put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) tx_bytes.push_back(v[8*i +: 8]);
    endfunction

    // minimal form most of the time, otherwise a random form that may be wider (non-minimal)
    function automatic void put_compact(input logic [63:0] v);
        int form;
        form = (v < 64'd253) ? 0 : (v < 64'h1_0000) ? 1 : (v < 64'h1_0000_0000) ? 2 : 3;
        if ($urandom_range(99) < 30) form = $urandom_range(3, form);
        case (form)
            0: tx_bytes.push_back(v[7:0]);
            1: begin tx_bytes.push_back(btxp_pkg::CS_PFX_16); put_le(v, 2); end
            2: begin tx_bytes.push_back(btxp_pkg::CS_PFX_32); put_le(v, 4); end
            default: begin tx_bytes.push_back(CS_PFX_64); put_le(v, 8); end
        endcase
    endfunction

    // empty scripts are frequent, a few scripts need the 3-byte length form
    function automatic int pick_script_len();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 0;
        if (r < 92) return $urandom_range(12, 1);
        return $urandom_range(300, 253);
    endfunction

    function automatic int pick_count();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 1;
            2:       return $urandom_range(2, 1);
            default: return $urandom_range(3, 2);
        endcase
    endfunction

    function automatic void build_tx(input int n_in, input int n_out);
        int slen;
        tx_bytes.delete();
        put_le({$urandom, $urandom}, 4);            // version
        put_compact(64'(n_in));
        for (int i = 0; i < n_in; i++) begin
            repeat (32) tx_bytes.push_back(8'($urandom));  // txid
            put_le({$urandom, $urandom}, 4);        // previous index
            slen = pick_script_len();
            put_compact(64'(slen));
            repeat (slen) tx_bytes.push_back(8'($urandom));
            put_le({$urandom, $urandom}, 4);        // sequence
        end
        put_compact(64'(n_out));
        for (int i = 0; i < n_out; i++) begin
            put_le({$urandom, $urandom}, 8);        // amount
            slen = pick_script_len();
            put_compact(64'(slen));
            repeat (slen) tx_bytes.push_back(8'($urandom));
        end
        put_le({$urandom, $urandom}, 4);            // lock time
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one input transaction per call, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        btxp_pkg::t_result r;
        while (!tx_fast && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        r = parse_byte(b, last);
        tagged_bytes.push_back(r);
        bytes_sent++;
        if (r.status == btxp_pkg::ST_OK) tx_ok_cnt++;
        if (r.status == btxp_pkg::ST_ERROR && last) tx_bad_cnt++;
        @(negedge i_clk);
    endtask

    // sends tx_bytes[0..cut], marking byte cut as the last one if asked
    task automatic send_stream(input int cut, input logic mark_end);
        for (int i = 0; i <= cut; i++) send_byte(tx_bytes[i], mark_end && (i == cut));
    endtask

    // sender goes quiet until every expected result has come back
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (tagged_bytes.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, occasional stall-free bursts, long hold on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (rx_burst_left != 0) begin
            rx_burst_left--;
            i_ready <= 1'b1;
        end else begin
            if ($urandom_range(99) < 2) rx_burst_left = $urandom_range(40, 10);
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        btxp_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tagged_bytes.size() == 0) begin
                $error("result with nothing expected: kind %0d byte %02h",
                       o_field_kind, o_byte_out);
                err_cnt++;
            end else begin
                want = tagged_bytes.pop_front();
                check_field("field_kind", 64'(want.field_kind), 64'(o_field_kind));
                check_field("byte_out", 64'(want.byte_out), 64'(o_byte_out));
                check_field("decoded_value", want.decoded_value, o_decoded_value);
                check_field("field_end", 64'(want.field_end), 64'(o_field_end));
                check_field("event_kind", 64'(want.event_kind), 64'(o_event_kind));
                check_field("element_number", want.element_number, o_element_number);
                check_field("status", 64'(want.status), 64'(o_status));
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no transaction on either channel for too long ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d results still pending", tagged_bytes.size());
                $display("bitcoin_tx_stream_parser regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // all-ones version, zero input count in 5-byte form, zero output count, ok
    task automatic test_directed_empty_tx();
        tx_bytes.delete();
        put_le(64'hffff_ffff, 4);
        tx_bytes.push_back(btxp_pkg::CS_PFX_32);
        put_le(64'd0, 4);
        tx_bytes.push_back(8'h00);
        put_le(64'd0, 4);
        send_stream(tx_bytes.size() - 1, 1'b1);
    endtask

    // buffer ends inside the version field
    task automatic test_directed_early_end();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // lock time arrives unmarked; following bytes are discarded up to the mark
    task automatic test_directed_run_past();
        tx_bytes.delete();
        put_le(64'd1, 4);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'h00);
        put_le(64'hffff_ffff, 4);
        send_stream(tx_bytes.size() - 1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hab, 1'b1);
    endtask

    // receiver holds off while the sender keeps offering: block fills, input
    // stalls; then the sender pauses until everything has drained
    task automatic test_backpressure();
        tx_fast     = 1'b1;
        rx_hold_req = LONG_HOLD;
        build_tx(1, 1);
        send_stream(tx_bytes.size() - 1, 1'b1);
        tx_fast = 1'b0;
        wait_results_done();
    endtask

    task automatic test_random_streams(input int unsigned n_bytes);
        int unsigned stop_at;
        int          r;
        logic [63:0] big;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            tx_fast = ($urandom_range(99) < 15);
            r = $urandom_range(99);
            if (r < 65) begin
                build_tx(pick_count(), pick_count());
                send_stream(tx_bytes.size() - 1, 1'b1);
            end else if (r < 80) begin
                // truncated anywhere before the final lock-time byte
                build_tx(pick_count(), pick_count());
                send_stream($urandom_range(tx_bytes.size() - 2, 0), 1'b1);
            end else if (r < 90) begin
                build_tx(pick_count(), pick_count());
                send_stream(tx_bytes.size() - 1, 1'b0);
                repeat ($urandom_range(4)) send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end else if (r < 95) begin
                // 9-byte count, all ones or a random 64-bit value, cut short
                big = $urandom_range(1) ? '1 : {$urandom, $urandom};
                tx_bytes.delete();
                put_le({$urandom, $urandom}, 4);
                if ($urandom_range(1)) tx_bytes.push_back(8'h00);
                tx_bytes.push_back(CS_PFX_64);
                put_le(big, 8);
                repeat ($urandom_range(40, 1)) tx_bytes.push_back(8'($urandom));
                send_stream(tx_bytes.size() - 1, 1'b1);
            end else begin
                tx_bytes.delete();
                repeat ($urandom_range(8, 1)) tx_bytes.push_back(8'($urandom));
                send_stream(tx_bytes.size() - 1, 1'b1);
            end
        end
        tx_fast = 1'b0;
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_last_byte   = 1'b0;
        i_ready       = 1'b0;
        tx_fast       = 1'b0;
        rx_hold_req   = 0;
        rx_hold_left  = 0;
        rx_burst_left = 0;
        stall_cycles  = 0;
        err_cnt       = 0;
        bytes_sent    = 0;
        results_seen  = 0;
        tx_ok_cnt     = 0;
        tx_bad_cnt    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 76;
        clear_parser();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_empty_tx();
        test_directed_early_end();
        test_directed_run_past();
        wait_results_done();
        test_backpressure();

        // a stream usually runs past the byte budget, so each phase ends long
        test_random_streams(220);
        send_idle_pct = 76;
        recv_idle_pct = 11;
        test_random_streams(220);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(220);

        // wait on for any stray results before the final check
        repeat (8) @(posedge i_clk);
        if (tagged_bytes.size() != 0) begin
            $error("%0d expected results never arrived", tagged_bytes.size());
            err_cnt++;
        end

        $display("covered %0d bytes: %0d txs parsed clean, %0d streams ended in read error",
                 bytes_sent, tx_ok_cnt, tx_bad_cnt);
        $display("%0d results checked, %0d mismatches", results_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("bitcoin_tx_stream_parser regression: pass");
        end else begin
            $display("bitcoin_tx_stream_parser regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/btxp_pkg.sv
rtl/btxp_step.sv
rtl/bitcoin_tx_stream_parser.sv
rtl/btxp_checker.sv
tb/tb_bitcoin_tx_stream_parser.sv
